>>> hw/rtl/tea_block_encrypt_macros.svh
// Assertion macros used by the checker file of the TEA encryption core.
// Depends on nothing; included by the files that assert.
`ifndef TEA_BLOCK_ENCRYPT_MACROS_SVH
`define TEA_BLOCK_ENCRYPT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TEA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("TEA checker: invariant violated");

// An antecedent that must imply a consequent, both sampled outside reset.
`define TEA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("TEA checker: implication violated");

`endif

>>> hw/rtl/tea_pkg.sv
// Types, constants and round functions of the TEA encryption core.
// Depends on nothing; imported by tea_block_encrypt and tea_checker.
`default_nettype none

package tea_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  // Golden-ratio increment of the running sum.
  localparam word_t TeaDelta = 32'h9e37_79b9;

  // Key words after reset.
  localparam word_t KeyWord0Rst = 32'h0300_2312;
  localparam word_t KeyWord1Rst = 32'h0335_2313;
  localparam word_t KeyWord2Rst = 32'h0300_2312;
  localparam word_t KeyWord3Rst = 32'h1234_5678;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    KeyWord0 = 2'd0,
    KeyWord1 = 2'd1,
    KeyWord2 = 2'd2,
    KeyWord3 = 2'd3
  } key_idx_e;

  // One TEA mixing term: ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb).
  function automatic word_t mix_term(word_t w, word_t sum, word_t ka, word_t kb);
    word_t a;
    word_t b;
    word_t c;
    a = (w << 4) + ka;
    b = w + sum;
    c = (w >> 5) + kb;
    return a ^ b ^ c;
  endfunction

  // Running sum seen in round r (counted from 0); evaluated at elaboration.
  function automatic word_t round_sum(int unsigned r);
    logic [63:0] prod;
    prod = 64'(r + 1) * 64'(TeaDelta);
    return prod[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tea_block_encrypt.sv
// Top level of the pipelined TEA block encryption core.
// Depends on tea_pkg (types, key reset values, mixing function).
//
//   Channel  | Direction | Handshake            | Beat
//   ---------+-----------+----------------------+-------------------------------
//   input    | in        | start_i, busy_o      | plain_left_i, plain_right_i
//   result   | out       | done_o (strobe)      | cipher_left_o, cipher_right_o
//   config   | in        | cfg_we_i, cfg_idx_i  | cfg_wdata_i (one key word)
//
// Every block passes 2*ROUND_COUNT register stages, one half-round (one
// Feistel word update) per stage. A new block may enter in every cycle;
// the throughput is one block per cycle.
// Reset clears all stage valid bits and loads the default key words.
// Nothing in the pipeline ever waits, so busy_o stays low; results are shown
// for exactly one cycle under done_o and the receiver takes each one.
`default_nettype none

module tea_block_encrypt #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input blocks.
  input  wire logic              start_i,
  output      logic              busy_o,
  input  wire tea_pkg::word_t    plain_left_i,
  input  wire tea_pkg::word_t    plain_right_i,
  // Results.
  output      logic              done_o,
  output      tea_pkg::word_t    cipher_left_o,
  output      tea_pkg::word_t    cipher_right_o,
  // Key configuration.
  input  wire logic              cfg_we_i,
  input  wire tea_pkg::key_idx_e cfg_idx_i,
  input  wire tea_pkg::word_t    cfg_wdata_i
);

  import tea_pkg::*;

  // Two stages per round: the left update, then the right update.
  localparam int unsigned NumStages = 2 * ROUND_COUNT;

  // Key registers. The user must change them only while the pipeline is empty;
  // the block does not enforce this, and every stage reads them directly.
  word_t key0_q, key1_q, key2_q, key3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= KeyWord0Rst;
      key1_q <= KeyWord1Rst;
      key2_q <= KeyWord2Rst;
      key3_q <= KeyWord3Rst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        KeyWord0: key0_q <= cfg_wdata_i;
        KeyWord1: key1_q <= cfg_wdata_i;
        KeyWord2: key2_q <= cfg_wdata_i;
        KeyWord3: key3_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // Stage registers: a valid bit and both data words per stage.
  logic  stg_valid_q [NumStages];
  word_t stg_left_q  [NumStages];
  word_t stg_right_q [NumStages];

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    // Round number of this stage and its constant running sum.
    localparam int unsigned Round = s / 2;
    localparam word_t       Sum   = round_sum(Round);

    logic  valid_in;
    word_t left_in;
    word_t right_in;
    word_t left_d;
    word_t right_d;

    if (s == 0) begin : g_first
      assign valid_in = start_i;
      assign left_in  = plain_left_i;
      assign right_in = plain_right_i;
    end else begin : g_chain
      assign valid_in = stg_valid_q[s-1];
      assign left_in  = stg_left_q[s-1];
      assign right_in = stg_right_q[s-1];
    end

    if ((s % 2) == 0) begin : g_left_half
      // Left word absorbs the right word with key words 0 and 1.
      always_comb begin
        left_d  = left_in + mix_term(right_in, Sum, key0_q, key1_q);
        right_d = right_in;
      end
    end else begin : g_right_half
      // Right word absorbs the freshly updated left word with key words 2 and 3.
      always_comb begin
        left_d  = left_in;
        right_d = right_in + mix_term(left_in, Sum, key2_q, key3_q);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_valid_q[s] <= 1'b0;
      end else begin
        stg_valid_q[s] <= valid_in;
      end
    end

    // Data words move only with a valid beat, which keeps idle stages quiet.
    always_ff @(posedge clk_i) begin
      if (valid_in) begin
        stg_left_q[s]  <= left_d;
        stg_right_q[s] <= right_d;
      end
    end
  end

  // The pipeline has no stall path, so an input beat is always taken.
  assign busy_o = 1'b0;

  assign done_o         = stg_valid_q[NumStages-1];
  assign cipher_left_o  = stg_left_q[NumStages-1];
  assign cipher_right_o = stg_right_q[NumStages-1];

endmodule

`default_nettype wire

>>> hw/rtl/tea_checker.sv
// Port-level checker for the TEA encryption core, bound to tea_block_encrypt.
// Depends on tea_pkg and tea_block_encrypt_macros.svh.
`default_nettype none

`include "tea_block_encrypt_macros.svh"

module tea_checker #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire logic           busy_o,
  input wire logic           done_o,
  input wire tea_pkg::word_t cipher_left_o,
  input wire tea_pkg::word_t cipher_right_o
);

  import tea_pkg::*;

  localparam int unsigned Latency = 2 * ROUND_COUNT;

  logic        in_beat;
  logic [63:0] out_blk;

  assign in_beat = start_i && !busy_o;
  assign out_blk = {cipher_left_o, cipher_right_o};

  // The core never refuses a beat.
  `TEA_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy_o)

  // Every accepted block comes out after exactly the pipeline latency.
  `TEA_ASSERT_IMPL(a_beat_to_done, clk_i, rst_ni, in_beat, ##Latency done_o)

  // No result strobe without an input beat one latency earlier.
  `TEA_ASSERT_IMPL(a_done_has_beat, clk_i, rst_ni, done_o, $past(in_beat, Latency))

  // A strobe with no matching beat on the next cycle ends the burst there.
  `TEA_ASSERT_IMPL(a_done_ends, clk_i, rst_ni, done_o && !$past(in_beat, Latency-1), ##1 !done_o)

  // A result beat always carries fully known ciphertext words.
  `TEA_ASSERT_IMPL(a_done_known, clk_i, rst_ni, done_o, !$isunknown(out_blk))

endmodule

bind tea_block_encrypt tea_checker #(
  .ROUND_COUNT(ROUND_COUNT)
) u_tea_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .cipher_left_o (cipher_left_o),
  .cipher_right_o(cipher_right_o)
);

`default_nettype wire
